[sv/chs_pkg.sv]
// Shared types and constants for the chained hash set.
package chs_pkg;

    localparam int NumBuckets = 64;
    localparam int ChainDepth = 8;
    localparam int ValueWidth = 32;
    localparam int BucketWidth = $clog2(NumBuckets);
    localparam int SlotWidth = $clog2(NumBuckets * ChainDepth);
    localparam int PosWidth = $clog2(ChainDepth);
    localparam int LenWidth = $clog2(ChainDepth + 1);
    localparam int CountWidth = 10;
    localparam int BcWidth = 7;
    localparam int DivCntWidth = $clog2(ValueWidth);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_SPARE  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_TEMPTY  = 3'd3;
    localparam logic [2:0] ST_BEMPTY  = 3'd4;
    localparam logic [2:0] ST_MISSING = 3'd5;

    localparam logic REG_BUCKET_COUNT = 1'b0;
    localparam logic [BcWidth-1:0] BucketCountReset = 7'd16;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] value;
        logic [5:0]  bucket;
    } in_word_t;

    typedef struct packed {
        logic        success;
        logic [2:0]  status;
        logic [9:0]  element_count;
        logic        table_empty;
    } out_word_t;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DIV   = 10'b0000000010,
        S_LREQ  = 10'b0000000100,
        S_LCHK  = 10'b0000001000,
        S_SREQ  = 10'b0000010000,
        S_SCMP  = 10'b0000100000,
        S_SHREQ = 10'b0001000000,
        S_SHWR  = 10'b0010000000,
        S_DEL   = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } state_t;

endpackage

[sv/chs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module chs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/chained_hash_set_top.sv]
// Top level of the chained hash set: sequencer, divider, chain walk and APB port.
//
// Usage:
// - in_valid/in_ready carry one command word (insert, delete, lookup).
// - out_valid/out_ready carry one result word per command.
// - APB register 0 (bucket_count) sets the hash modulus; a write clears the table.
// Sequence: insert first runs a one-bit-per-cycle restoring divider to
// form value mod bucket_count (clamped to 1..64), then reads the chain
// length, then compares chain entries in turn (at most 8). Delete and lookup
// skip the divider and end before the search on an empty table or on an
// empty or out-of-range bucket; a delete shifts each later entry down and
// then commits. The result register loads last. The next word is taken in
// the cycle after the result loads.
// One command is in flight at a time; in_ready is high only while idle.
// The result register holds while out_ready is low; the next command may be
// taken while a result waits, but it cannot finish until that one is taken.
// Reset empties the table and sets bucket_count to 16 at once; no sweep.
module chained_hash_set_top
    import chs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t                  state_reg, state_next;
    logic [BcWidth-1:0]      bc_reg;
    logic [CountWidth-1:0]   total_reg, total_next;
    logic [NumBuckets-1:0]   lvalid_reg;
    logic [1:0]              cmd_reg, cmd_next;
    logic [ValueWidth-1:0]   val_reg, val_next;
    logic [ValueWidth-1:0]   div_reg, div_next;
    logic [DivCntWidth-1:0]  cnt_reg, cnt_next;
    logic [BcWidth-1:0]      rem_reg, rem_next;
    logic [BucketWidth-1:0]  h_reg, h_next;
    logic [LenWidth-1:0]     len_reg, len_next;
    logic [LenWidth-1:0]     idx_reg, idx_next;
    logic [2:0]              status_reg, status_next;
    logic                    out_valid_reg;
    out_word_t               out_reg;

    logic [BcWidth-1:0]      eb;
    logic [BcWidth:0]        rem_sh;
    logic                    cfg_wr;
    logic [LenWidth-1:0]     len_cur;
    logic [LenWidth-1:0]     idx_inc;

    logic                    ent_we;
    logic [SlotWidth-1:0]    ent_waddr, ent_raddr;
    logic [ValueWidth-1:0]   ent_wdata, ent_rdata;
    logic                    len_we;
    logic [LenWidth-1:0]     len_wdata, len_rdata;

    chs_ram #(.WIDTH(ValueWidth), .DEPTH(NumBuckets * ChainDepth)) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    chs_ram #(.WIDTH(LenWidth), .DEPTH(NumBuckets)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (h_reg),
        .wdata (len_wdata),
        .raddr (h_reg),
        .rdata (len_rdata)
    );

    assign cfg_wr    = psel && penable && pwrite && (paddr[2] == REG_BUCKET_COUNT);
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_BUCKET_COUNT) ? {25'd0, bc_reg} : 32'd0;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign eb = (bc_reg == '0) ? BcWidth'(1) :
                (bc_reg > BcWidth'(NumBuckets)) ? BcWidth'(NumBuckets) : bc_reg;
    assign rem_sh  = {rem_reg, div_reg[ValueWidth-1]};
    assign len_cur = lvalid_reg[h_reg] ? len_rdata : '0;
    assign idx_inc = idx_reg + LenWidth'(1);

    always_comb
    begin
        state_next  = state_reg;
        total_next  = total_reg;
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        div_next    = div_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        h_next      = h_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        ent_we      = 1'b0;
        ent_waddr   = {h_reg, idx_reg[PosWidth-1:0]};
        ent_wdata   = val_reg;
        ent_raddr   = {h_reg, idx_reg[PosWidth-1:0]};
        len_we      = 1'b0;
        len_wdata   = len_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = in_data.command;
                    val_next = in_data.value;
                    div_next = in_data.value;
                    cnt_next = '0;
                    rem_next = '0;
                    h_next   = in_data.bucket;
                    if (in_data.command == CMD_INSERT)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_LREQ;
                    end
                end
            end
            S_DIV:
            begin
                if (rem_sh >= {1'b0, eb})
                begin
                    rem_next = BcWidth'(rem_sh - {1'b0, eb});
                end
                else
                begin
                    rem_next = rem_sh[BcWidth-1:0];
                end
                div_next = {div_reg[ValueWidth-2:0], 1'b0};
                cnt_next = cnt_reg + DivCntWidth'(1);
                if (cnt_reg == DivCntWidth'(ValueWidth - 1))
                begin
                    h_next     = rem_next[BucketWidth-1:0];
                    state_next = S_LREQ;
                end
            end
            S_LREQ:
            begin
                state_next = S_LCHK;
            end
            S_LCHK:
            begin
                len_next = len_cur;
                idx_next = '0;
                if (cmd_reg != CMD_INSERT && total_reg == '0)
                begin
                    status_next = ST_TEMPTY;
                    state_next  = S_FIN;
                end
                else if (cmd_reg != CMD_INSERT &&
                         ({1'b0, h_reg} >= eb || len_cur == '0))
                begin
                    status_next = ST_BEMPTY;
                    state_next  = S_FIN;
                end
                else if (len_cur != '0)
                begin
                    state_next = S_SREQ;
                end
                else
                begin
                    // empty bucket on insert: place at the head
                    ent_we      = 1'b1;
                    ent_waddr   = {h_reg, {PosWidth{1'b0}}};
                    len_we      = 1'b1;
                    len_wdata   = LenWidth'(1);
                    total_next  = total_reg + CountWidth'(1);
                    status_next = ST_OK;
                    state_next  = S_FIN;
                end
            end
            S_SREQ:
            begin
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (ent_rdata == val_reg)
                begin
                    if (cmd_reg == CMD_INSERT)
                    begin
                        status_next = ST_DUP;
                        state_next  = S_FIN;
                    end
                    else if (cmd_reg == CMD_DELETE)
                    begin
                        idx_next   = idx_inc;
                        state_next = (idx_inc < len_reg) ? S_SHREQ : S_DEL;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        state_next  = S_FIN;
                    end
                end
                else if (idx_inc < len_reg)
                begin
                    idx_next   = idx_inc;
                    state_next = S_SREQ;
                end
                else if (cmd_reg != CMD_INSERT)
                begin
                    status_next = ST_MISSING;
                    state_next  = S_FIN;
                end
                else if (len_reg >= LenWidth'(ChainDepth))
                begin
                    status_next = ST_FULL;
                    state_next  = S_FIN;
                end
                else
                begin
                    ent_we      = 1'b1;
                    ent_waddr   = {h_reg, len_reg[PosWidth-1:0]};
                    len_we      = 1'b1;
                    len_wdata   = len_reg + LenWidth'(1);
                    total_next  = total_reg + CountWidth'(1);
                    status_next = ST_OK;
                    state_next  = S_FIN;
                end
            end
            S_SHREQ:
            begin
                state_next = S_SHWR;
            end
            S_SHWR:
            begin
                ent_we    = 1'b1;
                ent_waddr = {h_reg, PosWidth'(idx_reg - LenWidth'(1))};
                ent_wdata = ent_rdata;
                idx_next  = idx_inc;
                state_next = (idx_inc < len_reg) ? S_SHREQ : S_DEL;
            end
            S_DEL:
            begin
                len_we      = 1'b1;
                len_wdata   = len_reg - LenWidth'(1);
                total_next  = total_reg - CountWidth'(1);
                status_next = ST_OK;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bc_reg        <= BucketCountReset;
            total_reg     <= '0;
            lvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                bc_reg     <= pwdata[BcWidth-1:0];
                total_reg  <= '0;
                lvalid_reg <= '0;
            end
            else
            begin
                total_reg <= total_next;
                if (len_we)
                begin
                    lvalid_reg[h_reg] <= 1'b1;
                end
            end
            if (state_reg == S_FIN && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        div_reg    <= div_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        h_reg      <= h_next;
        len_reg    <= len_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        if (state_reg == S_FIN && (!out_valid_reg || out_ready))
        begin
            out_reg.success       <= (status_reg == ST_OK);
            out_reg.status        <= status_reg;
            out_reg.element_count <= total_reg;
            out_reg.table_empty   <= (total_reg == '0);
        end
    end

endmodule
